FILE: src/prp_pkg.sv
// Shared widths, codes, reset values and bundle types for the point rotate/project block.
// No dependencies; every other file uses it by scoped names.
package prp_pkg;

    localparam int COORD_W     = 16;
    localparam int COEF_W      = 6;
    localparam int DIST_W      = 15;
    localparam int CENTER_W    = 10;
    localparam int CMD_W       = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;
    localparam int MUL_W       = COORD_W + COEF_W;   // coordinate times coefficient
    localparam int PROD_W      = 32;                 // coordinate times distance
    localparam int DEN_W       = 17;                 // signed rot_z + distance
    localparam int DIV_NUM_W   = 31;                 // dividend magnitude
    localparam int DIV_DEN_W   = 16;                 // divisor magnitude
    localparam int SUM_W       = 33;

    typedef enum logic [CMD_W-1:0] {
        CMD_ROT_X = 2'd0,
        CMD_ROT_Y = 2'd1,
        CMD_ROT_Z = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_COS      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIN      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIST     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_X = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_Y = 3'd4;

    localparam logic signed [COEF_W-1:0] COS_RESET      = 6'sd16;
    localparam logic signed [COEF_W-1:0] SIN_RESET      = 6'sd0;
    localparam logic [DIST_W-1:0]        DIST_RESET     = 15'd2400;
    localparam logic [CENTER_W-1:0]      CENTER_X_RESET = 10'd120;
    localparam logic [CENTER_W-1:0]      CENTER_Y_RESET = 10'd150;

    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } rot_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] rot_x;
        logic signed [COORD_W-1:0] rot_y;
        logic signed [COORD_W-1:0] rot_z;
        logic                      neg_x;
        logic                      neg_y;
        logic                      dz;
    } side_t;

    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] rot_x;
        logic signed [COORD_W-1:0] rot_y;
        logic signed [COORD_W-1:0] rot_z;
        logic signed [COORD_W-1:0] screen_x;
        logic signed [COORD_W-1:0] screen_y;
        logic                      dz;
    } res_t;

endpackage

FILE: src/point_rotate_project.sv
// Top level of the point rotate/project block: configuration registers and handshake.
// Depends on prp_pkg, prp_rotate and prp_project.
//
// Usage:
//   s_ channel: one point (s_px, s_py, s_pz, signed fixed point) and an axis command
//   per item. m_ channel: rotated point, screen position and a divide-by-zero flag.
//   Registers (cos, sin, view distance, centre x/y) are written through cfg_wr_en,
//   cfg_index and cfg_wdata; the user must write them only while no item is in flight,
//   as the block itself does not enforce it.
// Pipeline: 37 register stages: 2 rotation stages, 2 projection set-up stages,
//   31 divider stages (one quotient bit each) and 2 stages for sign and centre offset.
// Throughput: one item per cycle unless the output stalls; the bit-serial divider
//   pipeline is fully staged.
// Reset: aresetn clears every stage valid bit and loads the register defaults.
// Stall: when m_valid is high and m_ready low the whole pipeline holds, and s_ready
//   drops in the same cycle; nothing is lost or repeated.
module point_rotate_project #(
    parameter int FRAC_BITS      = 4,
    parameter int COEF_FRAC_BITS = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [prp_pkg::CMD_W-1:0]           s_command,
    input  logic signed [prp_pkg::COORD_W-1:0]  s_px,
    input  logic signed [prp_pkg::COORD_W-1:0]  s_py,
    input  logic signed [prp_pkg::COORD_W-1:0]  s_pz,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [prp_pkg::COORD_W-1:0]  m_rot_x,
    output logic signed [prp_pkg::COORD_W-1:0]  m_rot_y,
    output logic signed [prp_pkg::COORD_W-1:0]  m_rot_z,
    output logic signed [prp_pkg::COORD_W-1:0]  m_screen_x,
    output logic signed [prp_pkg::COORD_W-1:0]  m_screen_y,
    output logic                                m_divide_by_zero,
    input  logic                                cfg_wr_en,
    input  logic [prp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [prp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    logic signed [prp_pkg::COEF_W-1:0] cos_reg, sin_reg;
    logic [prp_pkg::DIST_W-1:0]        dist_reg;
    logic [prp_pkg::CENTER_W-1:0]      cx_reg, cy_reg;
    logic                              adv;
    prp_pkg::rot_t                     rot;
    prp_pkg::res_t                     res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg  <= prp_pkg::COS_RESET;
            sin_reg  <= prp_pkg::SIN_RESET;
            dist_reg <= prp_pkg::DIST_RESET;
            cx_reg   <= prp_pkg::CENTER_X_RESET;
            cy_reg   <= prp_pkg::CENTER_Y_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                prp_pkg::CFG_COS:      cos_reg  <= cfg_wdata[prp_pkg::COEF_W-1:0];
                prp_pkg::CFG_SIN:      sin_reg  <= cfg_wdata[prp_pkg::COEF_W-1:0];
                prp_pkg::CFG_DIST:     dist_reg <= cfg_wdata[prp_pkg::DIST_W-1:0];
                prp_pkg::CFG_CENTER_X: cx_reg   <= cfg_wdata[prp_pkg::CENTER_W-1:0];
                prp_pkg::CFG_CENTER_Y: cy_reg   <= cfg_wdata[prp_pkg::CENTER_W-1:0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // Advance every stage unless a finished item waits at the output
    assign adv     = !res.valid || m_ready;
    assign s_ready = adv;

    prp_rotate #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_rotate (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_valid),
        .in_cmd   (s_command),
        .in_x     (s_px),
        .in_y     (s_py),
        .in_z     (s_pz),
        .cos_coef (cos_reg),
        .sin_coef (sin_reg),
        .rot_out  (rot)
    );

    prp_project #(
        .FRAC_BITS (FRAC_BITS)
    ) u_project (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .rot_in        (rot),
        .view_distance (dist_reg),
        .center_x      (cx_reg),
        .center_y      (cy_reg),
        .res_out       (res)
    );

    assign m_valid          = res.valid;
    assign m_rot_x          = res.rot_x;
    assign m_rot_y          = res.rot_y;
    assign m_rot_z          = res.rot_z;
    assign m_screen_x       = res.screen_x;
    assign m_screen_y       = res.screen_y;
    assign m_divide_by_zero = res.dz;

    // A zero divisor zeroes the screen position
    a_dz_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> m_screen_x == '0 && m_screen_y == '0)
        else $error("screen position not zero on divide by zero");

    // A zero divisor needs rotated z to cancel the distance
    a_dz_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |->
            prp_pkg::DEN_W'(m_rot_z) + prp_pkg::DEN_W'(dist_reg) == '0)
        else $error("divide by zero flagged with nonzero divisor");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    // An output that is not taken stalls the input side
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

endmodule

FILE: src/prp_rotate.sv
// Two-stage rotation: coefficient products, then shift, combine and place per axis.
// Depends on prp_pkg.
module prp_rotate #(
    parameter int COEF_FRAC_BITS = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic [prp_pkg::CMD_W-1:0]           in_cmd,
    input  logic signed [prp_pkg::COORD_W-1:0]  in_x,
    input  logic signed [prp_pkg::COORD_W-1:0]  in_y,
    input  logic signed [prp_pkg::COORD_W-1:0]  in_z,
    input  logic signed [prp_pkg::COEF_W-1:0]   cos_coef,
    input  logic signed [prp_pkg::COEF_W-1:0]   sin_coef,
    output prp_pkg::rot_t                       rot_out
);

    logic signed [prp_pkg::COORD_W-1:0] a_sel, b_sel;
    logic signed [prp_pkg::MUL_W-1:0]   ac_next, bs_next, as_next, bc_next;

    logic                               v1_reg;
    prp_pkg::cmd_t                      cmd1_reg;
    logic signed [prp_pkg::COORD_W-1:0] x1_reg, y1_reg, z1_reg;
    logic signed [prp_pkg::MUL_W-1:0]   ac_reg, bs_reg, as_reg, bc_reg;

    logic signed [prp_pkg::MUL_W-1:0]   ac_sh, bs_sh, as_sh, bc_sh;
    logic signed [prp_pkg::MUL_W:0]     a_new, b_new;
    logic signed [prp_pkg::COORD_W-1:0] x_next, y_next, z_next;

    logic                               v2_reg;
    logic signed [prp_pkg::COORD_W-1:0] x2_reg, y2_reg, z2_reg;

    // Pick the pair (a, b) that turns: a' = a*c - b*s, b' = a*s + b*c
    always_comb begin
        case (prp_pkg::cmd_t'(in_cmd))
            prp_pkg::CMD_ROT_X: begin
                a_sel = in_y;
                b_sel = in_z;
            end
            prp_pkg::CMD_ROT_Y: begin
                a_sel = in_z;
                b_sel = in_x;
            end
            default: begin
                a_sel = in_x;
                b_sel = in_y;
            end
        endcase
    end

    assign ac_next = a_sel * cos_coef;
    assign bs_next = b_sel * sin_coef;
    assign as_next = a_sel * sin_coef;
    assign bc_next = b_sel * cos_coef;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cmd1_reg <= prp_pkg::cmd_t'(in_cmd);
            x1_reg   <= in_x;
            y1_reg   <= in_y;
            z1_reg   <= in_z;
            ac_reg   <= ac_next;
            bs_reg   <= bs_next;
            as_reg   <= as_next;
            bc_reg   <= bc_next;
        end
    end

    // Each product floors on its own before the add
    assign ac_sh = ac_reg >>> COEF_FRAC_BITS;
    assign bs_sh = bs_reg >>> COEF_FRAC_BITS;
    assign as_sh = as_reg >>> COEF_FRAC_BITS;
    assign bc_sh = bc_reg >>> COEF_FRAC_BITS;
    assign a_new = ac_sh - bs_sh;
    assign b_new = as_sh + bc_sh;

    always_comb begin
        x_next = x1_reg;
        y_next = y1_reg;
        z_next = z1_reg;
        case (cmd1_reg)
            prp_pkg::CMD_ROT_X: begin
                y_next = a_new[prp_pkg::COORD_W-1:0];
                z_next = b_new[prp_pkg::COORD_W-1:0];
            end
            prp_pkg::CMD_ROT_Y: begin
                z_next = a_new[prp_pkg::COORD_W-1:0];
                x_next = b_new[prp_pkg::COORD_W-1:0];
            end
            prp_pkg::CMD_ROT_Z: begin
                x_next = a_new[prp_pkg::COORD_W-1:0];
                y_next = b_new[prp_pkg::COORD_W-1:0];
            end
            default: begin
                x_next = x1_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x2_reg <= x_next;
            y2_reg <= y_next;
            z2_reg <= z_next;
        end
    end

    assign rot_out.valid = v2_reg;
    assign rot_out.x     = x2_reg;
    assign rot_out.y     = y2_reg;
    assign rot_out.z     = z2_reg;

endmodule

FILE: src/prp_divider.sv
// Pipelined restoring divider on magnitudes: one quotient bit per register stage.
// Depends on prp_pkg for the operand widths.
module prp_divider (
    input  logic                            aclk,
    input  logic                            adv,
    input  logic [prp_pkg::DIV_NUM_W-1:0]   in_num,
    input  logic [prp_pkg::DIV_DEN_W-1:0]   in_den,
    output logic [prp_pkg::DIV_NUM_W-1:0]   out_quo
);

    localparam int NW = prp_pkg::DIV_NUM_W;
    localparam int DW = prp_pkg::DIV_DEN_W;

    // quo_reg holds the unused dividend bits above and the quotient bits below
    logic [NW-1:0] quo_reg [NW];
    logic [DW-1:0] rem_reg [NW];
    logic [DW-1:0] den_reg [NW];

    logic [NW-1:0] quo_src [NW];
    logic [DW-1:0] rem_src [NW];
    logic [DW-1:0] den_src [NW];
    logic [DW:0]   trial   [NW];
    logic [DW:0]   diff    [NW];

    always_comb begin
        for (int k = 0; k < NW; k++) begin
            if (k == 0) begin
                quo_src[k] = in_num;
                rem_src[k] = '0;
                den_src[k] = in_den;
            end else begin
                quo_src[k] = quo_reg[k-1];
                rem_src[k] = rem_reg[k-1];
                den_src[k] = den_reg[k-1];
            end
            trial[k] = {rem_src[k], quo_src[k][NW-1]};
            diff[k]  = trial[k] - {1'b0, den_src[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NW; k++) begin
                den_reg[k] <= den_src[k];
                if (!diff[k][DW]) begin
                    rem_reg[k] <= diff[k][DW-1:0];
                    quo_reg[k] <= {quo_src[k][NW-2:0], 1'b1};
                end else begin
                    rem_reg[k] <= trial[k][DW-1:0];
                    quo_reg[k] <= {quo_src[k][NW-2:0], 1'b0};
                end
            end
        end
    end

    assign out_quo = quo_reg[NW-1];

endmodule

FILE: src/prp_project.sv
// Perspective projection: scale, sign split, two pipelined dividers, centre offset.
// Depends on prp_pkg and prp_divider.
module prp_project #(
    parameter int FRAC_BITS = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             adv,
    input  prp_pkg::rot_t                    rot_in,
    input  logic [prp_pkg::DIST_W-1:0]       view_distance,
    input  logic [prp_pkg::CENTER_W-1:0]     center_x,
    input  logic [prp_pkg::CENTER_W-1:0]     center_y,
    output prp_pkg::res_t                    res_out
);

    localparam int PW = prp_pkg::PROD_W;
    localparam int NW = prp_pkg::DIV_NUM_W;
    localparam int DW = prp_pkg::DIV_DEN_W;
    localparam int SW = prp_pkg::SUM_W;
    localparam int CW = prp_pkg::COORD_W;
    localparam logic [PW-1:0] NUM_MASK  = (PW'(1) << FRAC_BITS) - PW'(1);
    localparam logic [SW-1:0] FRAC_MASK = (SW'(1) << FRAC_BITS) - SW'(1);

    // Stage P1: products with the distance and the divisor
    logic signed [PW-1:0]              prod_x_next, prod_y_next;
    logic signed [prp_pkg::DEN_W-1:0]  den_next;
    logic                              p1_valid_reg;
    prp_pkg::rot_t                     p1_rot_reg;
    logic signed [PW-1:0]              prod_x_reg, prod_y_reg;
    logic signed [prp_pkg::DEN_W-1:0]  den_reg;

    assign prod_x_next = rot_in.x * $signed({1'b0, view_distance});
    assign prod_y_next = rot_in.y * $signed({1'b0, view_distance});
    assign den_next    = $signed({rot_in.z[CW-1], rot_in.z})
                       + $signed({2'b00, view_distance});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= rot_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_rot_reg <= rot_in;
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            den_reg    <= den_next;
        end
    end

    // Stage P2: drop fraction bits, split sign and magnitude
    logic [PW-1:0]        num_x, num_y, mag_x_full, mag_y_full;
    logic [prp_pkg::DEN_W-1:0] den_mag_full;
    logic                 den_neg;
    prp_pkg::side_t       side_next;
    logic                 p2_valid_reg;
    prp_pkg::side_t       p2_side_reg;
    logic [NW-1:0]        mag_x_reg, mag_y_reg;
    logic [DW-1:0]        den_mag_reg;

    assign num_x        = prod_x_reg & ~NUM_MASK;
    assign num_y        = prod_y_reg & ~NUM_MASK;
    assign mag_x_full   = num_x[PW-1] ? (PW'(0) - num_x) : num_x;
    assign mag_y_full   = num_y[PW-1] ? (PW'(0) - num_y) : num_y;
    assign den_neg      = den_reg[prp_pkg::DEN_W-1];
    assign den_mag_full = den_neg ? (prp_pkg::DEN_W'(0) - den_reg) : den_reg;

    always_comb begin
        side_next.rot_x = p1_rot_reg.x;
        side_next.rot_y = p1_rot_reg.y;
        side_next.rot_z = p1_rot_reg.z;
        side_next.neg_x = num_x[PW-1] ^ den_neg;
        side_next.neg_y = num_y[PW-1] ^ den_neg;
        side_next.dz    = (den_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (adv) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_side_reg <= side_next;
            mag_x_reg   <= mag_x_full[NW-1:0];
            mag_y_reg   <= mag_y_full[NW-1:0];
            den_mag_reg <= den_mag_full[DW-1:0];
        end
    end

    // Dividers, with the item's side data carried alongside
    logic [NW-1:0]   quo_x, quo_y;
    logic [NW-1:0]   vld_pipe_reg;
    prp_pkg::side_t  side_pipe_reg [NW];

    prp_divider u_div_x (
        .aclk    (aclk),
        .adv     (adv),
        .in_num  (mag_x_reg),
        .in_den  (den_mag_reg),
        .out_quo (quo_x)
    );

    prp_divider u_div_y (
        .aclk    (aclk),
        .adv     (adv),
        .in_num  (mag_y_reg),
        .in_den  (den_mag_reg),
        .out_quo (quo_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_pipe_reg <= '0;
        end else if (adv) begin
            vld_pipe_reg <= {vld_pipe_reg[NW-2:0], p2_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_pipe_reg[0] <= p2_side_reg;
            for (int k = 1; k < NW; k++) begin
                side_pipe_reg[k] <= side_pipe_reg[k-1];
            end
        end
    end

    // Stage Q1: restore the quotient sign
    logic                 q1_valid_reg;
    prp_pkg::side_t       q1_side_reg;
    logic signed [PW-1:0] qx_reg, qy_reg;
    logic [PW-1:0]        qx_next, qy_next;

    assign qx_next = side_pipe_reg[NW-1].neg_x ? (PW'(0) - PW'(quo_x)) : PW'(quo_x);
    assign qy_next = side_pipe_reg[NW-1].neg_y ? (PW'(0) - PW'(quo_y)) : PW'(quo_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q1_valid_reg <= 1'b0;
        end else if (adv) begin
            q1_valid_reg <= vld_pipe_reg[NW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q1_side_reg <= side_pipe_reg[NW-1];
            qx_reg      <= qx_next;
            qy_reg      <= qy_next;
        end
    end

    // Stage Q2: add the centre, truncate toward zero, wrap; zero on a zero divisor
    logic signed [SW-1:0] sum_x, sum_y, fl_x, fl_y;
    logic                 inc_x, inc_y;
    logic signed [CW-1:0] scr_x_next, scr_y_next;
    logic                 res_valid_reg;
    prp_pkg::side_t       res_side_reg;
    logic signed [CW-1:0] scr_x_reg, scr_y_reg;

    assign sum_x = SW'(qx_reg) + $signed(SW'(center_x) << FRAC_BITS);
    assign sum_y = SW'(qy_reg) + $signed(SW'(center_y) << FRAC_BITS);
    assign fl_x  = sum_x >>> FRAC_BITS;
    assign fl_y  = sum_y >>> FRAC_BITS;
    assign inc_x = sum_x[SW-1] && ((sum_x & FRAC_MASK) != '0);
    assign inc_y = sum_y[SW-1] && ((sum_y & FRAC_MASK) != '0);

    always_comb begin
        if (q1_side_reg.dz) begin
            scr_x_next = '0;
            scr_y_next = '0;
        end else begin
            scr_x_next = fl_x[CW-1:0] + CW'(inc_x);
            scr_y_next = fl_y[CW-1:0] + CW'(inc_y);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (adv) begin
            res_valid_reg <= q1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_side_reg <= q1_side_reg;
            scr_x_reg    <= scr_x_next;
            scr_y_reg    <= scr_y_next;
        end
    end

    assign res_out.valid    = res_valid_reg;
    assign res_out.rot_x    = res_side_reg.rot_x;
    assign res_out.rot_y    = res_side_reg.rot_y;
    assign res_out.rot_z    = res_side_reg.rot_z;
    assign res_out.screen_x = scr_x_reg;
    assign res_out.screen_y = scr_y_reg;
    assign res_out.dz       = res_side_reg.dz;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for point_rotate_project: directed rows and then random points, each result
// checked against its listed value or a register-tracking predictor. Depends on prp_pkg.
module testbench;

    localparam int     FRAC_BITS      = 4;
    localparam int     COEF_FRAC_BITS = 4;
    localparam longint SCALE          = longint'(1) << FRAC_BITS;
    localparam int     PIPE_LATENCY   = 37;
    localparam int     QUIET_LIMIT    = 2000;
    localparam int     SEGMENTS       = 5;
    localparam int     SEGMENT_ITEMS  = 130;

    typedef struct packed {
        logic signed [prp_pkg::COORD_W-1:0] rot_x;
        logic signed [prp_pkg::COORD_W-1:0] rot_y;
        logic signed [prp_pkg::COORD_W-1:0] rot_z;
        logic signed [prp_pkg::COORD_W-1:0] screen_x;
        logic signed [prp_pkg::COORD_W-1:0] screen_y;
        logic                               divide_by_zero;
    } point_result_t;

    typedef enum logic {ROW_POINT, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                           kind;
        prp_pkg::cmd_t                       cmd;
        logic signed [prp_pkg::COORD_W-1:0]  x;
        logic signed [prp_pkg::COORD_W-1:0]  y;
        logic signed [prp_pkg::COORD_W-1:0]  z;
        logic [prp_pkg::CFG_INDEX_W-1:0]     reg_index;
        logic [prp_pkg::CFG_DATA_W-1:0]      reg_value;
        logic                                has_want;
        point_result_t                       want;
    } stim_row_t;

    logic                                aclk;
    logic                                aresetn   = 1'b0;
    logic                                s_valid   = 1'b0;
    logic                                s_ready;
    logic [prp_pkg::CMD_W-1:0]           s_command = '0;
    logic signed [prp_pkg::COORD_W-1:0]  s_px      = '0;
    logic signed [prp_pkg::COORD_W-1:0]  s_py      = '0;
    logic signed [prp_pkg::COORD_W-1:0]  s_pz      = '0;
    logic                                m_valid;
    logic                                m_ready   = 1'b0;
    logic signed [prp_pkg::COORD_W-1:0]  m_rot_x;
    logic signed [prp_pkg::COORD_W-1:0]  m_rot_y;
    logic signed [prp_pkg::COORD_W-1:0]  m_rot_z;
    logic signed [prp_pkg::COORD_W-1:0]  m_screen_x;
    logic signed [prp_pkg::COORD_W-1:0]  m_screen_y;
    logic                                m_divide_by_zero;
    logic                                cfg_wr_en = 1'b0;
    logic [prp_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [prp_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;

    // register copies used by the predictor
    logic signed [prp_pkg::COEF_W-1:0]   rot_cos;
    logic signed [prp_pkg::COEF_W-1:0]   rot_sin;
    logic [prp_pkg::DIST_W-1:0]          view_dist;
    logic [prp_pkg::CENTER_W-1:0]        centre_x;
    logic [prp_pkg::CENTER_W-1:0]        centre_y;

    point_result_t pending_results[$];
    stim_row_t     directed_rows[$];
    int tx_idle_pct     = 0;
    int rx_idle_pct     = 0;
    int mismatches      = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int zero_div_seen   = 0;
    int settings_used   = 0;
    int quiet_cycles    = 0;

    point_rotate_project #(
        .FRAC_BITS      (FRAC_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_px             (s_px),
        .s_py             (s_py),
        .s_pz             (s_pz),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rot_x          (m_rot_x),
        .m_rot_y          (m_rot_y),
        .m_rot_z          (m_rot_z),
        .m_screen_x       (m_screen_x),
        .m_screen_y       (m_screen_y),
        .m_divide_by_zero (m_divide_by_zero),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // product of a coordinate and a coefficient, floored back to coordinate scale
    function automatic longint coef_product(longint a, longint c);
        return (a * c) >>> COEF_FRAC_BITS;
    endfunction

    function automatic logic signed [prp_pkg::COORD_W-1:0] project_axis(longint coord,
                                                                       longint den,
                                                                       longint centre);
        longint num;
        num = ((coord * longint'(view_dist)) >>> FRAC_BITS) * SCALE;
        return prp_pkg::COORD_W'((centre * SCALE + num / den) / SCALE);
    endfunction

    function automatic point_result_t rotate_and_project(
        prp_pkg::cmd_t cmd,
        logic signed [prp_pkg::COORD_W-1:0] x,
        logic signed [prp_pkg::COORD_W-1:0] y,
        logic signed [prp_pkg::COORD_W-1:0] z);
        point_result_t r;
        longint c;
        longint s;
        longint den;
        c = rot_cos;
        s = rot_sin;
        r = '0;
        r.rot_x = x;
        r.rot_y = y;
        r.rot_z = z;
        // sums wrap to 16 bits
        case (cmd)
            prp_pkg::CMD_ROT_X: begin
                r.rot_y = prp_pkg::COORD_W'(coef_product(y, c) - coef_product(z, s));
                r.rot_z = prp_pkg::COORD_W'(coef_product(y, s) + coef_product(z, c));
            end
            prp_pkg::CMD_ROT_Y: begin
                r.rot_x = prp_pkg::COORD_W'(coef_product(z, s) + coef_product(x, c));
                r.rot_z = prp_pkg::COORD_W'(coef_product(z, c) - coef_product(x, s));
            end
            prp_pkg::CMD_ROT_Z: begin
                r.rot_x = prp_pkg::COORD_W'(coef_product(x, c) - coef_product(y, s));
                r.rot_y = prp_pkg::COORD_W'(coef_product(x, s) + coef_product(y, c));
            end
            default: ;
        endcase
        den = longint'(r.rot_z) + longint'(view_dist);
        if (den == 0) begin
            r.divide_by_zero = 1'b1;
        end else begin
            r.screen_x = project_axis(r.rot_x, den, centre_x);
            r.screen_y = project_axis(r.rot_y, den, centre_y);
        end
        return r;
    endfunction

    task automatic table_point(input prp_pkg::cmd_t cmd, input int x, input int y,
                               input int z);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_POINT;
        row.cmd  = cmd;
        row.x    = x[prp_pkg::COORD_W-1:0];
        row.y    = y[prp_pkg::COORD_W-1:0];
        row.z    = z[prp_pkg::COORD_W-1:0];
        directed_rows.push_back(row);
    endtask

    task automatic table_known(input prp_pkg::cmd_t cmd, input int x, input int y,
                               input int z, input int rx, input int ry, input int rz,
                               input int sx, input int sy, input logic dz);
        stim_row_t row;
        row                     = '0;
        row.kind                = ROW_POINT;
        row.cmd                 = cmd;
        row.x                   = x[prp_pkg::COORD_W-1:0];
        row.y                   = y[prp_pkg::COORD_W-1:0];
        row.z                   = z[prp_pkg::COORD_W-1:0];
        row.has_want            = 1'b1;
        row.want.rot_x          = rx[prp_pkg::COORD_W-1:0];
        row.want.rot_y          = ry[prp_pkg::COORD_W-1:0];
        row.want.rot_z          = rz[prp_pkg::COORD_W-1:0];
        row.want.screen_x       = sx[prp_pkg::COORD_W-1:0];
        row.want.screen_y       = sy[prp_pkg::COORD_W-1:0];
        row.want.divide_by_zero = dz;
        directed_rows.push_back(row);
    endtask

    task automatic table_write(input logic [prp_pkg::CFG_INDEX_W-1:0] idx,
                               input int value);
        stim_row_t row;
        row           = '0;
        row.kind      = ROW_WRITE;
        row.reg_index = idx;
        row.reg_value = value[prp_pkg::CFG_DATA_W-1:0];
        directed_rows.push_back(row);
    endtask

    task automatic write_reg(input logic [prp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [prp_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            prp_pkg::CFG_COS:      rot_cos   = value[prp_pkg::COEF_W-1:0];
            prp_pkg::CFG_SIN:      rot_sin   = value[prp_pkg::COEF_W-1:0];
            prp_pkg::CFG_DIST:     view_dist = value[prp_pkg::DIST_W-1:0];
            prp_pkg::CFG_CENTER_X: centre_x  = value[prp_pkg::CENTER_W-1:0];
            prp_pkg::CFG_CENTER_Y: centre_y  = value[prp_pkg::CENTER_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // drop valid and hold until every outstanding result is back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic send_point(input prp_pkg::cmd_t cmd,
                              input logic signed [prp_pkg::COORD_W-1:0] x,
                              input logic signed [prp_pkg::COORD_W-1:0] y,
                              input logic signed [prp_pkg::COORD_W-1:0] z,
                              input logic has_want, input point_result_t want);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_px      <= x;
        s_py      <= y;
        s_pz      <= z;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(has_want ? want : rotate_and_project(cmd, x, y, z));
        items_sent++;
    endtask

    function automatic logic signed [prp_pkg::COORD_W-1:0] pick_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return prp_pkg::COORD_W'($urandom);
        if (pick < 85)
            return prp_pkg::COORD_W'(int'($urandom_range(1024)) - 512);
        case ($urandom_range(4))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'sh0001;
        endcase
    endfunction

    function automatic logic signed [prp_pkg::COEF_W-1:0] pick_coef();
        case ($urandom_range(9))
            0:       return 6'sd16;
            1:       return -6'sd16;
            2:       return 6'sd0;
            3:       return 6'sh20;
            4:       return 6'sd31;
            5:       return prp_pkg::COEF_W'($urandom);
            default: return prp_pkg::COEF_W'(int'($urandom_range(32)) - 16);
        endcase
    endfunction

    function automatic logic [prp_pkg::DIST_W-1:0] pick_dist();
        case ($urandom_range(9))
            0:       return 15'd0;
            1:       return 15'd1;
            2:       return 15'd32767;
            3:       return prp_pkg::DIST_W'($urandom);
            default: return prp_pkg::DIST_W'($urandom_range(4000, 16));
        endcase
    endfunction

    function automatic logic [prp_pkg::CENTER_W-1:0] pick_centre();
        case ($urandom_range(5))
            0:       return 10'd0;
            1:       return 10'd1023;
            default: return prp_pkg::CENTER_W'($urandom);
        endcase
    endfunction

    task automatic send_random_point();
        prp_pkg::cmd_t                      cmd;
        logic signed [prp_pkg::COORD_W-1:0] x;
        logic signed [prp_pkg::COORD_W-1:0] y;
        logic signed [prp_pkg::COORD_W-1:0] z;
        cmd = prp_pkg::cmd_t'($urandom_range(3));
        x   = pick_coord();
        y   = pick_coord();
        z   = pick_coord();
        // aim now and then at a zero divisor: z survives unchanged for these commands
        if ($urandom_range(99) < 6) begin
            cmd = $urandom_range(1) ? prp_pkg::CMD_NONE : prp_pkg::CMD_ROT_Z;
            z   = prp_pkg::COORD_W'(-longint'(view_dist));
        end
        send_point(cmd, x, y, z, 1'b0, '0);
    endtask

    task automatic check_field(input string name,
                               input logic signed [prp_pkg::COORD_W-1:0] want,
                               input logic signed [prp_pkg::COORD_W-1:0] got);
        if (got !== want) begin
            if (mismatches < 10)
                $display("result %0d %s: expected %0d, got %0d",
                         results_checked, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin : check_results
        point_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: rot %0d %0d %0d screen %0d %0d",
                             m_rot_x, m_rot_y, m_rot_z, m_screen_x, m_screen_y);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("rot_x", want.rot_x, m_rot_x);
                check_field("rot_y", want.rot_y, m_rot_y);
                check_field("rot_z", want.rot_z, m_rot_z);
                check_field("screen_x", want.screen_x, m_screen_x);
                check_field("screen_y", want.screen_y, m_screen_y);
                check_field("divide_by_zero", prp_pkg::COORD_W'(want.divide_by_zero),
                            prp_pkg::COORD_W'(m_divide_by_zero));
                if (m_divide_by_zero)
                    zero_div_seen++;
                results_checked++;
            end
        end
    end

    // watchdog: any handshake restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int phase;
        int seg;
        int n;
        rot_cos   = prp_pkg::COS_RESET;
        rot_sin   = prp_pkg::SIN_RESET;
        view_dist = prp_pkg::DIST_RESET;
        centre_x  = prp_pkg::CENTER_X_RESET;
        centre_y  = prp_pkg::CENTER_Y_RESET;

        // after reset the rotations are identities
        table_known(prp_pkg::CMD_NONE, 0, 0, 0, 0, 0, 0, 120, 150, 1'b0);
        table_known(prp_pkg::CMD_NONE, 32767, -32768, 0, 32767, -32768, 0, 2167, -1898,
                    1'b0);
        table_known(prp_pkg::CMD_NONE, 0, 0, -2400, 0, 0, -2400, 0, 0, 1'b1);
        table_point(prp_pkg::CMD_ROT_X, 100, -200, 300);
        table_point(prp_pkg::CMD_ROT_Y, -32768, 32767, -32768);
        table_point(prp_pkg::CMD_ROT_Z, 32767, 32767, 32767);
        table_point(prp_pkg::CMD_NONE, -1, -1, -1);
        // coefficients beyond one, used without saturation
        table_write(prp_pkg::CFG_COS, -32);
        table_write(prp_pkg::CFG_SIN, 31);
        table_point(prp_pkg::CMD_ROT_X, 1000, -1000, 500);
        table_point(prp_pkg::CMD_ROT_Y, 32767, -32768, 32767);
        table_point(prp_pkg::CMD_ROT_Z, -32768, -32768, 32767);
        table_write(prp_pkg::CFG_COS, 11);
        table_write(prp_pkg::CFG_SIN, -11);
        table_point(prp_pkg::CMD_ROT_X, 4000, -3000, 2000);
        table_point(prp_pkg::CMD_ROT_Y, -1234, 5678, -910);
        table_point(prp_pkg::CMD_ROT_Z, 16, -16, 1);
        table_write(prp_pkg::CFG_DIST, 0);
        table_known(prp_pkg::CMD_NONE, 5, 5, 0, 5, 5, 0, 0, 0, 1'b1);
        table_point(prp_pkg::CMD_ROT_Z, 100, 200, 0);
        table_point(prp_pkg::CMD_NONE, 16, -16, 16);
        table_point(prp_pkg::CMD_ROT_X, 0, 0, 0);
        table_write(prp_pkg::CFG_DIST, 32767);
        table_write(prp_pkg::CFG_CENTER_X, 1023);
        table_write(prp_pkg::CFG_CENTER_Y, 0);
        table_point(prp_pkg::CMD_NONE, 32767, 32767, -32768);
        table_known(prp_pkg::CMD_NONE, -32768, -32768, -32767, -32768, -32768, -32767,
                    0, 0, 1'b1);
        table_point(prp_pkg::CMD_ROT_Y, 20000, -20000, -20000);
        table_write(prp_pkg::CFG_CENTER_X, 0);
        table_write(prp_pkg::CFG_CENTER_Y, 1023);
        table_write(prp_pkg::CFG_DIST, 1);
        table_point(prp_pkg::CMD_NONE, 32767, -32768, 1);
        table_point(prp_pkg::CMD_NONE, -32768, 32767, -1);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 9;
        rx_idle_pct = 50;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                wait_for_results();
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end else begin
                send_point(directed_rows[i].cmd, directed_rows[i].x, directed_rows[i].y,
                           directed_rows[i].z, directed_rows[i].has_want,
                           directed_rows[i].want);
            end
        end

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 9;
                    rx_idle_pct = 50;
                end
                1: begin
                    tx_idle_pct = 50;
                    rx_idle_pct = 9;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (seg = 0; seg < SEGMENTS; seg++) begin
                wait_for_results();
                write_reg(prp_pkg::CFG_COS, prp_pkg::CFG_DATA_W'(pick_coef()));
                write_reg(prp_pkg::CFG_SIN, prp_pkg::CFG_DATA_W'(pick_coef()));
                write_reg(prp_pkg::CFG_DIST, pick_dist());
                write_reg(prp_pkg::CFG_CENTER_X, prp_pkg::CFG_DATA_W'(pick_centre()));
                write_reg(prp_pkg::CFG_CENTER_Y, prp_pkg::CFG_DATA_W'(pick_centre()));
                settings_used++;
                for (n = 0; n < SEGMENT_ITEMS; n++)
                    send_random_point();
            end
        end

        wait_for_results();
        repeat (PIPE_LATENCY + 20) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            mismatches++;
        end

        $display("Sent %0d points under %0d random register settings plus directed rows",
                 items_sent, settings_used);
        $display("Checked %0d results, %0d with a zero divisor, %0d mismatches",
                 results_checked, zero_div_seen, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
